>>> design/wsc_pkg.sv
package wsc_pkg;

   localparam int ANGLE_BITS_DEF = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_MAX     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_MIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_MAX     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_MIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_RATE_MAX = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRIVE_RADIUS = 3'd5;

   localparam logic [15:0] SPEED_MAX_RST     = 16'd6912;
   localparam logic [15:0] SPEED_MIN_RST     = 16'd51;
   localparam logic [14:0] ACCEL_MAX_RST     = 15'd1024;
   localparam logic [15:0] ACCEL_MIN_RST     = 16'hFE00;
   localparam logic [14:0] TURN_RATE_MAX_RST = 15'd182;
   localparam logic [23:0] ARRIVE_RADIUS_RST = 24'd25600;

   localparam logic [15:0] ANGLE_ZERO    = 16'h0000;
   localparam logic [15:0] QUARTER_TURN  = 16'h4000;
   localparam logic [15:0] HALF_TURN     = 16'h8000;
   localparam logic [15:0] THREE_QUARTER = 16'hC000;

   localparam int VEC_W      = 45;
   localparam int ROT_W      = 34;
   localparam int SQ_W       = 49;
   localparam int PROD_W     = 51;
   localparam int SQRT_STEPS = 25;
   localparam int ITER_W     = 5;
   localparam int NORM_BIT   = 40;

   localparam logic [ROT_W-1:0] KINV_Q30  = 34'd652032874;
   localparam logic [31:0]      RECIP3    = 32'hAAAAAAAB;
   localparam logic [24:0]      DIST_FAR  = 25'h0010000;

   localparam logic [31:0] ATAN_TAB [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_PLACE, OP_PREP, OP_SETUP, OP_SQX, OP_SQY, OP_RAD, OP_ARR,
      OP_SQRT, OP_DIV, OP_NORM, OP_BEAR, OP_BFIN, OP_HEAD, OP_CAP, OP_LIMIT, OP_ROT,
      OP_QUAD, OP_MULX, OP_MULY, OP_POS, OP_OUT
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_PREP, ST_SETUP, ST_SQX, ST_SQY, ST_RAD, ST_ARR, ST_SQRT, ST_DIV,
      ST_NORM, ST_BEAR, ST_BFIN, ST_HEAD, ST_CAP, ST_LIMIT, ST_ROT, ST_QUAD, ST_MULX,
      ST_MULY, ST_POS, ST_DONE
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [ITER_W-1:0]   iter;
   } cmd_type;

   typedef struct packed {
      logic place;
      logic norm_done;
   } status_type;

   typedef struct packed {
      logic               mode;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic [15:0]        leader_heading;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] position_x;
      logic signed [31:0] position_y;
      logic [15:0]        speed;
      logic [15:0]        heading;
      logic signed [15:0] turn_rate;
      logic signed [15:0] acceleration;
      logic               arrived;
   } rsp_payload_type;

   function automatic logic [23:0] angle_step(input logic [ITER_W-1:0] i, input int ab);
      logic [32:0] t;
      t = 33'd0;
      if (i < ITER_W'(24)) begin
         t = ({1'b0, ATAN_TAB[i]} + (33'd1 << (31 - ab))) >> (32 - ab);
      end
      return t[23:0];
   endfunction

endpackage

>>> design/wsc_req_if.sv
interface wsc_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [31:0] target_x;
   logic signed [31:0] target_y;
   logic [15:0]        leader_heading;

   modport source (output valid, mode, target_x, target_y, leader_heading, input ready);
   modport sink (input valid, mode, target_x, target_y, leader_heading, output ready);
endinterface

>>> design/wsc_rsp_if.sv
interface wsc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] position_x;
   logic signed [31:0] position_y;
   logic [15:0]        speed;
   logic [15:0]        heading;
   logic signed [15:0] turn_rate;
   logic signed [15:0] acceleration;
   logic               arrived;

   modport source (output valid, position_x, position_y, speed, heading, turn_rate,
                   acceleration, arrived, input ready);
   modport sink (input valid, position_x, position_y, speed, heading, turn_rate,
                 acceleration, arrived, output ready);
endinterface

>>> design/wsc_ctrl.sv
module wsc_ctrl #(
   parameter int ANGLE_BITS = wsc_pkg::ANGLE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  wsc_pkg::status_type status,
   output wsc_pkg::cmd_type    cmd
);
   import wsc_pkg::*;

   localparam logic [ITER_W-1:0] CORDIC_LAST = ITER_W'(ANGLE_BITS - 1);
   localparam logic [ITER_W-1:0] SQRT_LAST   = ITER_W'(SQRT_STEPS - 1);

   state_type         state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_PREP;
         ST_PREP:  state_in = status.place ? ST_DONE : ST_SETUP;
         ST_SETUP: state_in = ST_SQX;
         ST_SQX:   state_in = ST_SQY;
         ST_SQY:   state_in = ST_RAD;
         ST_RAD:   state_in = ST_ARR;
         ST_ARR:   state_in = ST_SQRT;
         ST_SQRT:  if (iter_ff == SQRT_LAST) state_in = ST_DIV;
         ST_DIV:   state_in = ST_NORM;
         ST_NORM:  if (status.norm_done) state_in = ST_BEAR;
         ST_BEAR:  if (iter_ff == CORDIC_LAST) state_in = ST_BFIN;
         ST_BFIN:  state_in = ST_HEAD;
         ST_HEAD:  state_in = ST_CAP;
         ST_CAP:   state_in = ST_LIMIT;
         ST_LIMIT: state_in = ST_ROT;
         ST_ROT:   if (iter_ff == CORDIC_LAST) state_in = ST_QUAD;
         ST_QUAD:  state_in = ST_MULX;
         ST_MULX:  state_in = ST_MULY;
         ST_MULY:  state_in = ST_POS;
         ST_POS:   state_in = ST_DONE;
         ST_DONE:  if (!valid_ff || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op    = OP_NONE;
      cmd.iter  = iter_ff;
      req_ready = 1'b0;
      iter_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_PREP:  cmd.op = status.place ? OP_PLACE : OP_PREP;
         ST_SETUP: cmd.op = OP_SETUP;
         ST_SQX:   cmd.op = OP_SQX;
         ST_SQY:   cmd.op = OP_SQY;
         ST_RAD:   cmd.op = OP_RAD;
         ST_ARR:   cmd.op = OP_ARR;
         ST_SQRT: begin
            cmd.op = OP_SQRT;
            if (iter_ff != SQRT_LAST) iter_in = iter_ff + ITER_W'(1);
         end
         ST_DIV:   cmd.op = OP_DIV;
         ST_NORM:  cmd.op = status.norm_done ? OP_NONE : OP_NORM;
         ST_BEAR: begin
            cmd.op = OP_BEAR;
            if (iter_ff != CORDIC_LAST) iter_in = iter_ff + ITER_W'(1);
         end
         ST_BFIN:  cmd.op = OP_BFIN;
         ST_HEAD:  cmd.op = OP_HEAD;
         ST_CAP:   cmd.op = OP_CAP;
         ST_LIMIT: cmd.op = OP_LIMIT;
         ST_ROT: begin
            cmd.op = OP_ROT;
            if (iter_ff != CORDIC_LAST) iter_in = iter_ff + ITER_W'(1);
         end
         ST_QUAD:  cmd.op = OP_QUAD;
         ST_MULX:  cmd.op = OP_MULX;
         ST_MULY:  cmd.op = OP_MULY;
         ST_POS:   cmd.op = OP_POS;
         ST_DONE:  if (!valid_ff || rsp_ready) cmd.op = OP_OUT;
         default:  cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.op == OP_OUT) valid_in = 1'b1;
      else if (rsp_ready) valid_in = 1'b0;
   end

   assign rsp_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         valid_ff <= valid_in;
      end
   end

endmodule

>>> design/wsc_dp.sv
module wsc_dp #(
   parameter int ANGLE_BITS = wsc_pkg::ANGLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  wsc_pkg::cmd_type                    cmd,
   output wsc_pkg::status_type                 status,
   input  wsc_pkg::req_payload_type            req_data,
   output wsc_pkg::rsp_payload_type            rsp_data,
   input  logic                                csr_wr_en,
   input  logic [wsc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wsc_pkg::CSR_DATA_W-1:0]      csr_wr_data
);
   import wsc_pkg::*;

   localparam int AB = ANGLE_BITS;
   localparam int S  = AB - 16;
   localparam int ZW = AB + 2;

   logic [15:0]        smax_ff, smax_in, smin_ff, smin_in;
   logic [14:0]        amax_ff, amax_in, trm_ff, trm_in;
   logic signed [15:0] amin_ff, amin_in;
   logic [23:0]        rad_ff, rad_in;

   logic signed [31:0] posx_ff, posx_in, posy_ff, posy_in;
   logic [15:0]        speed_ff, speed_in, head_ff, head_in;
   logic signed [15:0] accel_ff, accel_in;

   logic               mode_ff, mode_in;
   logic signed [31:0] tx_ff, tx_in, ty_ff, ty_in;
   logic [15:0]        lh_ff, lh_in;
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic               far_ff, far_in, arr_ff, arr_in;
   logic [23:0]        ax_ff, ax_in, ay_ff, ay_in;
   logic [SQ_W-1:0]    sq_ff, sq_in, sv_ff, sv_in, sr_ff, sr_in;
   logic [47:0]        rad2_ff, rad2_in;
   logic [24:0]        dist_ff, dist_in;
   logic signed [VEC_W-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [AB-1:0]      bz_ff, bz_in;
   logic               bsp_ff, bsp_in;
   logic [15:0]        bspv_ff, bspv_in, bear_ff, bear_in;
   logic signed [15:0] turn_ff, turn_in;
   logic [15:0]        e2_ff, e2_in, cap_ff, cap_in;
   logic signed [ROT_W-1:0] rx_ff, rx_in, ry_ff, ry_in, co_ff, co_in, si_ff, si_in;
   logic signed [ZW-1:0] rz_ff, rz_in;
   logic [1:0]         quad_ff, quad_in;
   logic signed [PROD_W-1:0] px_ff, px_in, py_ff, py_in;
   rsp_payload_type    out_ff, out_in;

   logic [15:0]        bear_raw;
   logic [AB-1:0]      h_ang;

   generate
      if (S > 0) begin : g_wide
         logic [AB:0] bz_rnd;
         assign bz_rnd   = {1'b0, bz_ff} + ((AB+1)'(1) << (S - 1));
         assign bear_raw = bz_rnd[S+15:S];
         assign h_ang    = {head_ff, {S{1'b0}}};
      end else if (S == 0) begin : g_even
         assign bear_raw = bz_ff[15:0];
         assign h_ang    = head_ff[AB-1:0];
      end else begin : g_narrow
         assign bear_raw = {bz_ff, {(-S){1'b0}}};
         assign h_ang    = head_ff[15:16-AB];
      end
   endgenerate

   logic [VEC_W-1:0] vy_mag, vmax;
   always_comb begin
      vy_mag           = vy_ff[VEC_W-1] ? VEC_W'(-vy_ff) : VEC_W'(vy_ff);
      vmax             = (vy_mag > VEC_W'(vx_ff)) ? vy_mag : VEC_W'(vx_ff);
      status.norm_done = bsp_ff || (|vmax[VEC_W-1:NORM_BIT]);
      status.place     = mode_ff;
   end

   always_comb begin
      smax_in = smax_ff;
      smin_in = smin_ff;
      amax_in = amax_ff;
      amin_in = amin_ff;
      trm_in  = trm_ff;
      rad_in  = rad_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SPEED_MAX:     smax_in = csr_wr_data[15:0];
            CSR_SPEED_MIN:     smin_in = csr_wr_data[15:0];
            CSR_ACCEL_MAX:     amax_in = csr_wr_data[14:0];
            CSR_ACCEL_MIN:     amin_in = $signed(csr_wr_data[15:0]);
            CSR_TURN_RATE_MAX: trm_in  = csr_wr_data[14:0];
            CSR_ARRIVE_RADIUS: rad_in  = csr_wr_data[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [32:0]             axw, ayw;
      logic [23:0]             stp;
      logic signed [VEC_W-1:0] xs, ys;
      logic                    ypos;
      logic [SQ_W-1:0]         bb, bsum;
      logic [56:0]             qprod;
      logic [15:0]             tgt, ediff, e2diff, newh, cap2, tsp;
      logic signed [16:0]      err, e2s, trm_s;
      logic [16:0]             e2abs;
      logic [30:0]             cprod;
      logic signed [17:0]      acc, spd;
      logic [AB-1:0]           hq, rr;
      logic [1:0]              q;
      logic signed [ROT_W-1:0] rxs, rys;
      logic signed [PROD_W-1:0] rndx, rndy;
      logic signed [51:0]      sumx, sumy;

      axw = '0; ayw = '0; stp = '0; xs = '0; ys = '0; ypos = 1'b0;
      bb = '0; bsum = '0; qprod = '0; tgt = '0; ediff = '0; e2diff = '0; newh = '0;
      cap2 = '0; tsp = '0; err = '0; e2s = '0; trm_s = '0; e2abs = '0; cprod = '0;
      acc = '0; spd = '0; hq = '0; rr = '0; q = '0; rxs = '0; rys = '0;
      rndx = '0; rndy = '0; sumx = '0; sumy = '0;

      posx_in = posx_ff; posy_in = posy_ff; speed_in = speed_ff; head_in = head_ff;
      accel_in = accel_ff; mode_in = mode_ff; tx_in = tx_ff; ty_in = ty_ff; lh_in = lh_ff;
      dx_in = dx_ff; dy_in = dy_ff; far_in = far_ff; arr_in = arr_ff; ax_in = ax_ff;
      ay_in = ay_ff; sq_in = sq_ff; sv_in = sv_ff; sr_in = sr_ff; rad2_in = rad2_ff;
      dist_in = dist_ff; vx_in = vx_ff; vy_in = vy_ff; bz_in = bz_ff; bsp_in = bsp_ff;
      bspv_in = bspv_ff; bear_in = bear_ff; turn_in = turn_ff; e2_in = e2_ff;
      cap_in = cap_ff; rx_in = rx_ff; ry_in = ry_ff; rz_in = rz_ff; quad_in = quad_ff;
      co_in = co_ff; si_in = si_ff; px_in = px_ff; py_in = py_ff; out_in = out_ff;

      unique case (cmd.op)
         OP_NONE: ;
         OP_LOAD: begin
            mode_in = req_data.mode;
            tx_in   = req_data.target_x;
            ty_in   = req_data.target_y;
            lh_in   = req_data.leader_heading;
         end
         OP_PLACE: begin
            posx_in  = tx_ff;
            posy_in  = ty_ff;
            head_in  = lh_ff;
            speed_in = '0;
            accel_in = '0;
            turn_in  = '0;
            arr_in   = 1'b0;
         end
         OP_PREP: begin
            dx_in = $signed({tx_ff[31], tx_ff}) - $signed({posx_ff[31], posx_ff});
            dy_in = $signed({ty_ff[31], ty_ff}) - $signed({posy_ff[31], posy_ff});
         end
         OP_SETUP: begin
            axw    = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
            ayw    = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
            ax_in  = axw[23:0];
            ay_in  = ayw[23:0];
            far_in = (|axw[32:24]) || (|ayw[32:24]);
            vx_in  = dx_ff[32] ? -{{12{dx_ff[32]}}, dx_ff} : {{12{dx_ff[32]}}, dx_ff};
            vy_in  = dx_ff[32] ? -{{12{dy_ff[32]}}, dy_ff} : {{12{dy_ff[32]}}, dy_ff};
            bz_in  = dx_ff[32] ? {1'b1, {(AB-1){1'b0}}} : '0;
            bsp_in = (dx_ff == '0) || (dy_ff == '0);
            if (dy_ff == '0) bspv_in = dx_ff[32] ? HALF_TURN : ANGLE_ZERO;
            else bspv_in = dy_ff[32] ? THREE_QUARTER : QUARTER_TURN;
         end
         OP_SQX: sq_in = SQ_W'(ax_ff * ax_ff);
         OP_SQY: sq_in = sq_ff + SQ_W'(ay_ff * ay_ff);
         OP_RAD: rad2_in = rad_ff * rad_ff;
         OP_ARR: begin
            arr_in = !far_ff && (sq_ff < {1'b0, rad2_ff});
            sv_in  = sq_ff;
            sr_in  = '0;
         end
         OP_SQRT: begin
            bb   = SQ_W'(1) << (6'd48 - {cmd.iter, 1'b0});
            bsum = sr_ff + bb;
            if (sv_ff >= bsum) begin
               sv_in = sv_ff - bsum;
               sr_in = (sr_ff >> 1) + bb;
            end else begin
               sr_in = sr_ff >> 1;
            end
         end
         OP_DIV: begin
            qprod   = sr_ff[24:0] * RECIP3;
            dist_in = far_ff ? DIST_FAR : {1'b0, qprod[56:33]};
         end
         OP_NORM: begin
            if (vmax[VEC_W-1:32] == '0) begin
               vx_in = vx_ff <<< 8;
               vy_in = vy_ff <<< 8;
            end else begin
               vx_in = vx_ff <<< 1;
               vy_in = vy_ff <<< 1;
            end
         end
         OP_BEAR: begin
            stp  = angle_step(cmd.iter, AB);
            xs   = vx_ff >>> cmd.iter;
            ys   = vy_ff >>> cmd.iter;
            ypos = !vy_ff[VEC_W-1] && (vy_ff != '0);
            if (ypos) begin
               vx_in = vx_ff + ys;
               vy_in = vy_ff - xs;
               bz_in = bz_ff + stp[AB-1:0];
            end else begin
               vx_in = vx_ff - ys;
               vy_in = vy_ff + xs;
               bz_in = bz_ff - stp[AB-1:0];
            end
         end
         OP_BFIN: bear_in = bsp_ff ? bspv_ff : bear_raw;
         OP_HEAD: begin
            tgt   = arr_ff ? lh_ff : bear_ff;
            ediff = tgt - head_ff;
            err   = (ediff == HALF_TURN) ? 17'sd32768 : $signed({ediff[15], ediff});
            trm_s = $signed({2'b00, trm_ff});
            if (err > trm_s) err = trm_s;
            else if (err < -trm_s) err = -trm_s;
            turn_in = err[15:0];
            newh    = head_ff + err[15:0];
            head_in = newh;
            e2diff  = tgt - newh;
            e2s     = (e2diff == HALF_TURN) ? 17'sd32768 : $signed({e2diff[15], e2diff});
            e2abs   = e2s[16] ? 17'(-e2s) : 17'(e2s);
            e2_in   = e2abs[15:0];
         end
         OP_CAP: begin
            if (e2_ff < QUARTER_TURN) begin
               cprod  = smax_ff * 15'(QUARTER_TURN - e2_ff);
               cap_in = cprod[29:14];
            end else begin
               cap_in = '0;
            end
         end
         OP_LIMIT: begin
            cap2 = (cap_ff < smin_ff) ? smin_ff : cap_ff;
            tsp  = (dist_ff > {9'b0, cap2}) ? cap2 : dist_ff[15:0];
            acc  = $signed({2'b00, tsp}) - $signed({2'b00, speed_ff});
            if (acc > $signed({3'b000, amax_ff})) acc = $signed({3'b000, amax_ff});
            else if (acc < $signed({{2{amin_ff[15]}}, amin_ff})) begin
               acc = $signed({{2{amin_ff[15]}}, amin_ff});
            end
            accel_in = acc[15:0];
            spd = $signed({2'b00, speed_ff}) + acc;
            if (spd > $signed({2'b00, smax_ff})) spd = $signed({2'b00, smax_ff});
            else if (spd < $signed({2'b00, smin_ff})) spd = $signed({2'b00, smin_ff});
            speed_in = spd[15:0];
            hq      = h_ang + (AB'(1) << (AB - 3));
            q       = hq[AB-1:AB-2];
            rr      = h_ang - {q, {(AB-2){1'b0}}};
            quad_in = q;
            rz_in   = $signed({{2{rr[AB-1]}}, rr});
            rx_in   = $signed(KINV_Q30);
            ry_in   = '0;
         end
         OP_ROT: begin
            stp = angle_step(cmd.iter, AB);
            rxs = rx_ff >>> cmd.iter;
            rys = ry_ff >>> cmd.iter;
            if (!rz_ff[ZW-1]) begin
               rx_in = rx_ff - rys;
               ry_in = ry_ff + rxs;
               rz_in = rz_ff - $signed({2'b00, stp[AB-1:0]});
            end else begin
               rx_in = rx_ff + rys;
               ry_in = ry_ff - rxs;
               rz_in = rz_ff + $signed({2'b00, stp[AB-1:0]});
            end
         end
         OP_QUAD: begin
            case (quad_ff)
               2'd0: begin co_in = rx_ff;  si_in = ry_ff;  end
               2'd1: begin co_in = -ry_ff; si_in = rx_ff;  end
               2'd2: begin co_in = -rx_ff; si_in = -ry_ff; end
               default: begin co_in = ry_ff; si_in = -rx_ff; end
            endcase
         end
         OP_MULX: px_in = $signed({1'b0, speed_ff}) * co_ff;
         OP_MULY: py_in = $signed({1'b0, speed_ff}) * si_ff;
         OP_POS: begin
            rndx = (px_ff + (PROD_W'(1) <<< 29)) >>> 30;
            rndy = (py_ff + (PROD_W'(1) <<< 29)) >>> 30;
            sumx = 52'(posx_ff) + 52'(rndx);
            sumy = 52'(posy_ff) + 52'(rndy);
            if (sumx > 52'sh7FFFFFFF) posx_in = 32'sh7FFFFFFF;
            else if (sumx < -52'sh80000000) posx_in = -32'sh80000000;
            else posx_in = sumx[31:0];
            if (sumy > 52'sh7FFFFFFF) posy_in = 32'sh7FFFFFFF;
            else if (sumy < -52'sh80000000) posy_in = -32'sh80000000;
            else posy_in = sumy[31:0];
         end
         OP_OUT: begin
            out_in.position_x   = posx_ff;
            out_in.position_y   = posy_ff;
            out_in.speed        = speed_ff;
            out_in.heading      = head_ff;
            out_in.turn_rate    = turn_ff;
            out_in.acceleration = accel_ff;
            out_in.arrived      = arr_ff;
         end
         default: ;
      endcase
   end

   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         smax_ff  <= SPEED_MAX_RST;
         smin_ff  <= SPEED_MIN_RST;
         amax_ff  <= ACCEL_MAX_RST;
         amin_ff  <= ACCEL_MIN_RST;
         trm_ff   <= TURN_RATE_MAX_RST;
         rad_ff   <= ARRIVE_RADIUS_RST;
         posx_ff  <= '0;
         posy_ff  <= '0;
         speed_ff <= '0;
         accel_ff <= '0;
         head_ff  <= '0;
         mode_ff  <= 1'b0;
         bsp_ff   <= 1'b0;
         vx_ff    <= '0;
         vy_ff    <= '0;
      end else begin
         smax_ff  <= smax_in;
         smin_ff  <= smin_in;
         amax_ff  <= amax_in;
         amin_ff  <= amin_in;
         trm_ff   <= trm_in;
         rad_ff   <= rad_in;
         posx_ff  <= posx_in;
         posy_ff  <= posy_in;
         speed_ff <= speed_in;
         accel_ff <= accel_in;
         head_ff  <= head_in;
         mode_ff  <= mode_in;
         bsp_ff   <= bsp_in;
         vx_ff    <= vx_in;
         vy_ff    <= vy_in;
      end
   end

   always_ff @(posedge clock) begin
      tx_ff   <= tx_in;
      ty_ff   <= ty_in;
      lh_ff   <= lh_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      far_ff  <= far_in;
      arr_ff  <= arr_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      sq_ff   <= sq_in;
      sv_ff   <= sv_in;
      sr_ff   <= sr_in;
      rad2_ff <= rad2_in;
      dist_ff <= dist_in;
      bz_ff   <= bz_in;
      bspv_ff <= bspv_in;
      bear_ff <= bear_in;
      turn_ff <= turn_in;
      e2_ff   <= e2_in;
      cap_ff  <= cap_in;
      rx_ff   <= rx_in;
      ry_ff   <= ry_in;
      rz_ff   <= rz_in;
      quad_ff <= quad_in;
      co_ff   <= co_in;
      si_ff   <= si_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      out_ff  <= out_in;
   end

endmodule

>>> design/waypoint_steering_controller_core.sv
// Waypoint steering controller: one request is one tick of a single vehicle. A steer tick
// includes input normalization ahead of the bearing (none for a target on an axis); the two
// CORDIC passes (vectoring for the bearing, rotation for cos/sin), one iteration per cycle,
// and the 25-step bit-pair square root run on a shared datapath.
// A place tick skips these steps. One request is in flight at a time; a finished result
// waits in the output register and the next request is taken meanwhile. Configuration writes
// should apply to the next tick; the block itself does not enforce this.
module waypoint_steering_controller_core #(
   parameter int ANGLE_BITS = wsc_pkg::ANGLE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   wsc_req_if.sink                        req_chan,
   wsc_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [wsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wsc_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import wsc_pkg::*;

   cmd_type         cmd;
   status_type      status;
   req_payload_type req_data;
   rsp_payload_type rsp_data;

   assign req_data.mode           = req_chan.mode;
   assign req_data.target_x       = req_chan.target_x;
   assign req_data.target_y       = req_chan.target_y;
   assign req_data.leader_heading = req_chan.leader_heading;

   assign rsp_chan.position_x   = rsp_data.position_x;
   assign rsp_chan.position_y   = rsp_data.position_y;
   assign rsp_chan.speed        = rsp_data.speed;
   assign rsp_chan.heading      = rsp_data.heading;
   assign rsp_chan.turn_rate    = rsp_data.turn_rate;
   assign rsp_chan.acceleration = rsp_data.acceleration;
   assign rsp_chan.arrived      = rsp_data.arrived;

   wsc_ctrl #(.ANGLE_BITS(ANGLE_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wsc_dp #(.ANGLE_BITS(ANGLE_BITS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (cmd.op == OP_PLACE || cmd.op == OP_PREP))
      else $error("transfer not followed by tick start");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUT) |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result register overwritten while held");

   a_norm_before_bear: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_BEAR) |-> status.norm_done)
      else $error("bearing iteration on unnormalized vector");

endmodule
